>>> rtl/core/msas_pkg.sv
// Package for the multi-slot alarm scheduler: slot count, function codes,
// sequencer states and the input/result transfer structs. No dependencies.
package msas_pkg;

  // Number of alarm slots (1 to 16) and widths derived from it
  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned TICK_W     = 64;
  localparam int unsigned IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Function codes of an input transfer
  typedef enum logic [1:0] {
    FUNC_ARM    = 2'd0,
    FUNC_DISARM = 2'd1,
    FUNC_EVENT  = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRE,
    ST_MIN,
    ST_FINAL
  } state_e;

  // Input transfer payload
  typedef struct packed {
    logic [1:0]        func;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] due_tick;
    logic [TICK_W-1:0] now;
  } in_item_t;

  // Result transfer payload
  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] fired_slot;
    logic [TICK_W-1:0] fired_target;
    logic              alarm_on;
    logic [TICK_W-1:0] alarm_value;
    logic              ignored;
    logic              last;
  } out_item_t;

  // Flags from the shared magnitude comparator
  typedef struct packed {
    logic lt;
    logic le;
  } cmp_res_t;

endpackage

>>> rtl/core/msas_cmp.sv
// Shared 64-bit unsigned magnitude comparator of the alarm scheduler.
// Depends on msas_pkg for the tick width and the result struct.
module msas_cmp import msas_pkg::*; (
  input  logic [TICK_W-1:0] a_i,
  input  logic [TICK_W-1:0] b_i,
  output cmp_res_t          res_o
);

  // One wide subtract-style compare gives both flags
  always_comb begin
    res_o.lt = (a_i < b_i);
    res_o.le = res_o.lt | (a_i == b_i);
  end

endmodule

>>> rtl/core/multi_slot_alarm_scheduler.sv
// Multi-slot one-shot alarm scheduler: slot table, walk sequencer, output register.
// Depends on msas_pkg and msas_cmp (one comparator shared by both slot walks).
// An arm/disarm/ignored item walks the slots once (minimum walk) before its final result;
// an alarm event walks them twice (fire walk, then minimum walk); any result can stall on the output.
// Throughput: one item at a time, next accepted in the cycle after its final result is loaded.
// Reset clears all armed flags and the sequencer; targets are not reset.
module multi_slot_alarm_scheduler import msas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         cnt_q, cnt_d;
  logic [SLOT_COUNT-1:0]    armed_q, armed_d;
  logic [TICK_W-1:0]        target_q [SLOT_COUNT];
  logic [TICK_W-1:0]        now_q;
  logic [TICK_W-1:0]        nearest_q;
  logic                     any_q;
  logic                     ignored_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic                     in_xfer;
  logic                     slot_ok;
  logic                     out_free;
  logic                     cnt_last;
  logic [TICK_W-1:0]        cmp_b;
  cmp_res_t                 cmp_res;
  logic                     fire_hit;
  logic                     emit_fire;
  logic                     step_fire;
  logic                     min_take;
  logic                     emit_final;

  // Shared comparator: slot target against now (fire walk) or running minimum
  assign cmp_b = (state_q == ST_FIRE) ? now_q : nearest_q;

  msas_cmp u_cmp (
    .a_i   (target_q[cnt_q]),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  assign slot_ok  = ({1'b0, in_data_i.slot} < (SLOT_W+1)'(SLOT_COUNT));
  assign cnt_last = (cnt_q == IDX_W'(SLOT_COUNT - 1));
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_xfer    = in_valid_i && in_ready_o;
    fire_hit   = armed_q[cnt_q] && cmp_res.le;
    emit_fire  = (state_q == ST_FIRE) && fire_hit && out_free;
    step_fire  = (state_q == ST_FIRE) && (!fire_hit || out_free);
    min_take   = (state_q == ST_MIN) && armed_q[cnt_q] && (!any_q || cmp_res.lt);
    emit_final = (state_q == ST_FINAL) && out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (in_data_i.func == FUNC_EVENT) ? ST_FIRE : ST_MIN;
        end
      end
      ST_FIRE: begin
        if (step_fire && cnt_last) state_d = ST_MIN;
      end
      ST_MIN: begin
        if (cnt_last) state_d = ST_FINAL;
      end
      ST_FINAL: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Slot counter and armed flags
  always_comb begin
    cnt_d   = cnt_q;
    armed_d = armed_q;
    if (in_xfer) begin
      cnt_d = '0;
      if (slot_ok) begin
        if (in_data_i.func == FUNC_ARM)    armed_d[in_data_i.slot[IDX_W-1:0]] = 1'b1;
        if (in_data_i.func == FUNC_DISARM) armed_d[in_data_i.slot[IDX_W-1:0]] = 1'b0;
      end
    end
    if (emit_fire) armed_d[cnt_q] = 1'b0;
    if (step_fire || (state_q == ST_MIN)) begin
      cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      armed_q     <= '0;
      any_q       <= 1'b0;
      ignored_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      armed_q     <= armed_d;
      out_valid_q <= (out_valid_q && !out_ready_i) || emit_fire || emit_final;
      if (in_xfer) begin
        any_q <= 1'b0;
        case (in_data_i.func) inside
          FUNC_ARM, FUNC_DISARM: ignored_q <= !slot_ok;
          FUNC_EVENT:            ignored_q <= 1'b0;
          default:               ignored_q <= 1'b1;
        endcase
      end else if (min_take) begin
        any_q <= 1'b1;
      end
    end
  end

  // Slot targets, item time, running minimum and result register
  always_ff @(posedge clk_i) begin
    if (in_xfer && slot_ok && (in_data_i.func == FUNC_ARM)) begin
      target_q[in_data_i.slot[IDX_W-1:0]] <= in_data_i.due_tick;
    end
    if (in_xfer) now_q <= in_data_i.now;
    if (min_take) nearest_q <= target_q[cnt_q];
    if (emit_fire) begin
      out_q.fired        <= 1'b1;
      out_q.fired_slot   <= SLOT_W'(cnt_q);
      out_q.fired_target <= target_q[cnt_q];
      out_q.alarm_on     <= 1'b0;
      out_q.alarm_value  <= '0;
      out_q.ignored      <= 1'b0;
      out_q.last         <= 1'b0;
    end else if (emit_final) begin
      out_q.fired        <= 1'b0;
      out_q.fired_slot   <= '0;
      out_q.fired_target <= '0;
      out_q.alarm_on     <= any_q;
      out_q.alarm_value  <= any_q ? nearest_q : '0;
      out_q.ignored      <= ignored_q;
      out_q.last         <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> test/multi_slot_alarm_scheduler_tb.sv
// Testbench for multi_slot_alarm_scheduler: directed and random arm/disarm/event
// transfers, with results checked field by field against a slot-table predictor.
// Depends on msas_pkg and the scheduler RTL only.
module multi_slot_alarm_scheduler_tb;
  import msas_pkg::*;

  // Command waiting to be sent; hold_for_drain makes the sender wait for all results
  typedef struct {
    in_item_t data;
    bit       hold_for_drain;
  } alarm_cmd_t;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // Predictor state: the slot table as seen from outside
  bit                slot_live [SLOT_COUNT];
  logic [TICK_W-1:0] slot_tick [SLOT_COUNT];

  alarm_cmd_t cmd_q[$];
  out_item_t  alarm_results_q[$];
  int unsigned err_cnt = 0;

  multi_slot_alarm_scheduler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // Apply one command to the slot table and queue the results it should produce
  task automatic schedule_alarm_cmd(input in_item_t it);
    out_item_t         r;
    bit                skip;
    bit                any_live;
    logic [TICK_W-1:0] nearest;
    skip     = 1'b0;
    any_live = 1'b0;
    nearest  = '0;
    case (func_e'(it.func)) inside
      FUNC_ARM, FUNC_DISARM: begin
        if (it.slot >= SLOT_COUNT) begin
          skip = 1'b1;
        end else if (func_e'(it.func) == FUNC_ARM) begin
          slot_tick[it.slot] = it.due_tick;
          slot_live[it.slot] = 1'b1;
        end else begin
          slot_live[it.slot] = 1'b0;
        end
      end
      FUNC_EVENT: begin
        // due slots fire in ascending order, each disarmed as it fires
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_live[i] && slot_tick[i] <= it.now) begin
            r              = '0;
            r.fired        = 1'b1;
            r.fired_slot   = SLOT_W'(i);
            r.fired_target = slot_tick[i];
            alarm_results_q.push_back(r);
            slot_live[i] = 1'b0;
          end
        end
      end
      default: begin
        skip = 1'b1;
      end
    endcase
    // earliest pending target becomes the alarm value of the final result
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_live[i] && (!any_live || slot_tick[i] < nearest)) begin
        nearest  = slot_tick[i];
        any_live = 1'b1;
      end
    end
    r             = '0;
    r.alarm_on    = any_live;
    r.alarm_value = any_live ? nearest : '0;
    r.ignored     = skip;
    r.last        = 1'b1;
    alarm_results_q.push_back(r);
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_alarm_result(input out_item_t got);
    out_item_t want;
    if (alarm_results_q.size() == 0) begin
      report($sformatf("unexpected result %h", got));
    end else begin
      want = alarm_results_q.pop_front();
      if (got.fired !== want.fired)
        report($sformatf("fired %b, expected %b", got.fired, want.fired));
      if (got.fired_slot !== want.fired_slot)
        report($sformatf("fired_slot %0d, expected %0d", got.fired_slot, want.fired_slot));
      if (got.fired_target !== want.fired_target)
        report($sformatf("fired_target %h, expected %h", got.fired_target,
                         want.fired_target));
      if (got.alarm_on !== want.alarm_on)
        report($sformatf("alarm_on %b, expected %b", got.alarm_on, want.alarm_on));
      if (got.alarm_value !== want.alarm_value)
        report($sformatf("alarm_value %h, expected %h", got.alarm_value,
                         want.alarm_value));
      if (got.ignored !== want.ignored)
        report($sformatf("ignored %b, expected %b", got.ignored, want.ignored));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    end
  endtask

  task automatic add_cmd(input func_e fn, input logic [SLOT_W-1:0] sl,
                         input logic [TICK_W-1:0] tgt, input logic [TICK_W-1:0] nw,
                         input bit drain);
    alarm_cmd_t c;
    c.data.func        = fn;
    c.data.slot        = sl;
    c.data.due_tick    = tgt;
    c.data.now         = nw;
    c.hold_for_drain   = drain;
    cmd_q.push_back(c);
  endtask

  function automatic logic [TICK_W-1:0] rand_tick();
    return {$urandom, $urandom};
  endfunction

  // Sender: bursts of transfers separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : sender
    bit       took;
    bit       nxt_valid;
    in_item_t nxt_data;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        schedule_alarm_cmd(in_data_i);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          burst_left = $urandom_range(1, 12);
        end
      end
      if (!in_valid_i || took) begin
        nxt_valid = 1'b0;
        nxt_data  = in_data_i;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0 &&
                     !(cmd_q[0].hold_for_drain && alarm_results_q.size() != 0)) begin
          nxt_valid = 1'b1;
          nxt_data  = cmd_q.pop_front().data;
        end
        in_valid_i <= nxt_valid;
        in_data_i  <= nxt_data;
      end
    end
  end

  // Receiver: checks transfers; stalls on its own pattern, plus one long hold-off
  int unsigned rx_cyc    = 0;
  int unsigned rx_mode   = 0;
  int unsigned res_cnt   = 0;
  int unsigned hold_cnt  = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    bit nxt_ready;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_alarm_result(out_data_o);
        res_cnt++;
      end
      rx_cyc++;
      if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        nxt_ready = 1'b0;
      end else if (!hold_done && res_cnt >= 60) begin
        hold_done = 1'b1;
        hold_cnt  = 200;
        nxt_ready = 1'b0;
      end else begin
        case (rx_mode)
          0:       nxt_ready = 1'b1;
          1:       nxt_ready = ($urandom_range(0, 9) < 7);
          2:       nxt_ready = (rx_cyc % 5 == 0);
          default: nxt_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready_i <= nxt_ready;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    logic [TICK_W-1:0] tick;
    logic [TICK_W-1:0] tgt;
    logic [TICK_W-1:0] nw;
    logic [SLOT_W-1:0] sl;
    func_e             fn;
    int unsigned       pick;
    int unsigned       n_live;

    // directed: extremes, every function, special cases
    add_cmd(FUNC_ARM,    0,  '0,       TICK_MAX, 1'b0);
    add_cmd(FUNC_ARM,    3,  TICK_MAX, '0,       1'b0);
    add_cmd(FUNC_EVENT,  0,  TICK_MAX, '0,       1'b0);   // slot 0 fires at now 0
    add_cmd(FUNC_ARM,    1,  64'd5,    '0,       1'b0);
    add_cmd(FUNC_ARM,    1,  64'd10,   '0,       1'b0);   // re-arm replaces target
    add_cmd(FUNC_DISARM, 2,  TICK_MAX, TICK_MAX, 1'b0);   // idle slot, no flag
    add_cmd(FUNC_ARM,    4,  64'd1,    '0,       1'b0);   // out of range
    add_cmd(FUNC_DISARM, 15, '0,       '0,       1'b0);   // out of range
    add_cmd(FUNC_RSVD,   2,  TICK_MAX, TICK_MAX, 1'b0);   // unused function code
    add_cmd(FUNC_EVENT,  15, '0,       64'd9,    1'b0);   // slot field ignored, nothing due
    add_cmd(FUNC_ARM,    2,  64'd10,   '0,       1'b0);
    add_cmd(FUNC_EVENT,  7,  '0,       64'd10,   1'b0);   // target equal to now fires
    add_cmd(FUNC_EVENT,  0,  '0,       TICK_MAX, 1'b0);   // all-ones target fires last
    add_cmd(FUNC_ARM,    0,  64'h8000_0000_0000_0000, '0, 1'b0);
    add_cmd(FUNC_ARM,    1,  64'd3,    '0,       1'b0);
    add_cmd(FUNC_ARM,    2,  TICK_MAX - 1, '0,   1'b0);
    add_cmd(FUNC_ARM,    3,  64'd3,    '0,       1'b0);
    add_cmd(FUNC_DISARM, 1,  '0,       '0,       1'b0);
    add_cmd(FUNC_ARM,    1,  64'd2,    '0,       1'b0);
    add_cmd(FUNC_EVENT,  0,  '0,       TICK_MAX, 1'b0);   // every slot fires
    add_cmd(FUNC_EVENT,  0,  '0,       TICK_MAX, 1'b1);   // nothing armed, alarm off

    // random: mostly targets near a running tick so that events really fire
    tick   = rand_tick();
    n_live = 0;
    while (n_live < 229) begin
      if ($urandom_range(0, 39) == 0) tick = ($urandom_range(0, 1) == 0) ? rand_tick() : '0;
      sl   = ($urandom_range(0, 6) == 0) ? SLOT_W'($urandom_range(0, 15))
                                         : SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
      tgt  = rand_tick();
      nw   = rand_tick();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        fn   = FUNC_ARM;
        pick = $urandom_range(0, 19);
        if (pick == 0)      tgt = TICK_MAX;
        else if (pick == 1) tgt = '0;
        else if (pick > 3)  tgt = tick + $urandom_range(0, 120);
      end else if (pick < 55) begin
        fn = FUNC_DISARM;
      end else if (pick < 94) begin
        fn   = FUNC_EVENT;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          nw = TICK_MAX;
        end else if (pick > 2) begin
          nw   = tick + $urandom_range(0, 60);
          tick = nw;
        end
      end else begin
        fn = FUNC_RSVD;
      end
      add_cmd(fn, sl, tgt, nw, (n_live == 130));
      n_live++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i || alarm_results_q.size() != 0)
      @(posedge clk_i);
    repeat (4 * SLOT_COUNT + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
